// ===== rtl/cef_pkg.sv =====
// Shared types and constants of the cross erosion filter.
// Holds the request payload structs, register map codes and fixed field widths.
// No dependencies; every file of the block imports it.
`default_nettype none

package cef_pkg;

  localparam int CODE_W   = 8;    // pixel code width
  localparam int WIDTH_W  = 11;   // image_width register width
  localparam int ROW_W    = 16;   // image_height register and row counter width
  localparam int POS_W    = ROW_W + WIDTH_W;  // raster position of the input side

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  // register map, word index into the APB space
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FOREGROUND_CODE = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_BACKGROUND_CODE = 2'd3;

  // reset values of the registers
  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST     = 11'd1024;
  localparam logic [ROW_W-1:0]   IMAGE_HEIGHT_RST    = 16'd1;
  localparam logic [CODE_W-1:0]  FOREGROUND_CODE_RST = 8'd35;
  localparam logic [CODE_W-1:0]  BACKGROUND_CODE_RST = 8'd46;

  // request opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic              op;
    logic [CODE_W-1:0] pixel_in;
  } cef_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] pixel_out;
    logic              row_end;
    logic              frame_end;
  } cef_out_t;

endpackage

`default_nettype wire

// ===== rtl/cross_erosion_filter.sv =====
// Cross erosion filter: 4-neighbour binary erosion over a raster pixel stream.
// Result for pixel t: registered in the compute stage after request t+W+1, then queued.
// Throughput: one request per cycle while the result queue has room, set by the single
// read-modify-write pass over both line memories (1R/1W ports each, W = 1 forwarded).
// Reset (rst, synchronous, active high) clears counters, queue and registers to
// width 1024, height 1, foreground 35, background 46; line memories are not cleared.
`default_nettype none

module cross_erosion_filter
  import cef_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // pixel requests
  input  wire logic                  pix_valid,
  output      logic                  pix_ready,
  input  wire cef_in_t               pix_req,
  // eroded pixel requests
  output      logic                  ero_valid,
  input  wire logic                  ero_ready,
  output      cef_out_t              ero_req,
  // APB-style register port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output      logic [CFG_DATA_W-1:0] prdata,
  output      logic                  pready
);

  // Column counters address the line memories; XW is wide enough for both the
  // register value and MAX_WIDTH itself so the clamp compare never truncates.
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int XW = (AW + 1 > WIDTH_W) ? AW + 1 : WIDTH_W;
  localparam logic [XW-1:0] MAXW_X = XW'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] ROW_MAX = '1;

  // Result queue between the compute stage and the output port.
  localparam int QD  = 4;
  localparam int QAW = 2;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WIDTH_W-1:0] cfg_width;
  logic [ROW_W-1:0]   cfg_height;
  logic [CODE_W-1:0]  cfg_fg;
  logic [CODE_W-1:0]  cfg_bg;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 geom_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[REG_IDX_W+1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  // a geometry write restarts the frame
  assign geom_wr = cfg_wr && (cfg_idx == REG_IMAGE_WIDTH || cfg_idx == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= IMAGE_WIDTH_RST;
      cfg_height <= IMAGE_HEIGHT_RST;
      cfg_fg     <= FOREGROUND_CODE_RST;
      cfg_bg     <= BACKGROUND_CODE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:     cfg_width  <= pwdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:    cfg_height <= pwdata[ROW_W-1:0];
        REG_FOREGROUND_CODE: cfg_fg     <= pwdata[CODE_W-1:0];
        REG_BACKGROUND_CODE: cfg_bg     <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:     prdata = CFG_DATA_W'(cfg_width);
      REG_IMAGE_HEIGHT:    prdata = CFG_DATA_W'(cfg_height);
      REG_FOREGROUND_CODE: prdata = CFG_DATA_W'(cfg_fg);
      REG_BACKGROUND_CODE: prdata = CFG_DATA_W'(cfg_bg);
      default:             prdata = '0;
    endcase
  end

  // Effective geometry: width 0 acts as 1 and is clamped to the line memory depth,
  // height 0 acts as 1.
  logic [XW-1:0]    w_eff;
  logic [XW-1:0]    w_last;
  logic [ROW_W-1:0] h_eff;
  logic [ROW_W-1:0] h_last;

  always_comb begin
    if (cfg_width == '0) begin
      w_eff = XW'(1);
    end else if (XW'(cfg_width) > MAXW_X) begin
      w_eff = MAXW_X;
    end else begin
      w_eff = XW'(cfg_width);
    end
    h_eff  = (cfg_height == '0) ? ROW_W'(1) : cfg_height;
    w_last = w_eff - XW'(1);
    h_last = h_eff - ROW_W'(1);
  end

  // ---------------------------------------------------------------------------
  // Request side: raster counters of the input and of the next result
  // ---------------------------------------------------------------------------
  logic [AW-1:0]    in_col;
  logic [ROW_W-1:0] in_row;
  logic [POS_W-1:0] in_pos;     // in_row * W + in_col, kept incrementally
  logic [AW-1:0]    out_col;
  logic [ROW_W-1:0] out_row;
  logic             wrapped;    // input row counter rolled over inside a frame

  logic accept;
  logic in_frame;
  logic step;
  logic has_res;
  logic out_col_last;
  logic out_row_last;
  logic last;
  logic col_last;

  assign accept       = pix_valid && pix_ready;
  assign in_frame     = in_row < h_eff;
  // a flush before the frame is complete changes nothing
  assign step         = accept && !(in_frame && pix_req.op == OP_FLUSH);
  assign has_res      = in_pos >= (POS_W'(w_eff) + POS_W'(1));
  assign out_col_last = XW'(out_col) == w_last;
  assign out_row_last = out_row == h_last;
  assign last         = has_res && out_col_last && out_row_last;
  assign col_last     = XW'(in_col) == w_last;

  always_ff @(posedge clk) begin
    if (rst || geom_wr || (step && last)) begin
      in_col  <= '0;
      in_row  <= '0;
      in_pos  <= '0;
      out_col <= '0;
      out_row <= '0;
      wrapped <= 1'b0;
    end else if (step) begin
      if (has_res) begin
        if (out_col_last) begin
          out_col <= '0;
          out_row <= out_row + ROW_W'(1);
        end else begin
          out_col <= out_col + AW'(1);
        end
      end
      if (col_last) begin
        in_col <= '0;
        in_row <= in_row + ROW_W'(1);
        // the position wraps together with the row counter
        if (in_row == ROW_MAX) begin
          in_pos  <= '0;
          wrapped <= 1'b1;
        end else begin
          in_pos <= in_pos + POS_W'(1);
        end
      end else begin
        in_col <= in_col + AW'(1);
        in_pos <= in_pos + POS_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line memories: read at the input column on a step, written back in the next cycle, not later
  // ---------------------------------------------------------------------------
  logic [CODE_W-1:0] upper_mem  [MAX_WIDTH];
  logic [CODE_W-1:0] middle_mem [MAX_WIDTH];
  logic [CODE_W-1:0] upper_q;
  logic [CODE_W-1:0] middle_q;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CODE_W-1:0] upper_wdata;
  logic [CODE_W-1:0] middle_wdata;

  // the frame-ending step leaves the memories untouched
  assign rd_en   = step && !last;
  assign rd_addr = in_col;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_q <= upper_mem[rd_addr];
    end
    if (wr_en) begin
      upper_mem[wr_addr] <= upper_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      middle_q <= middle_mem[rd_addr];
    end
    if (wr_en) begin
      middle_mem[wr_addr] <= middle_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Compute stage: one step per cycle, never stalls
  // ---------------------------------------------------------------------------
  logic              s1_valid;
  logic              s1_wr;
  logic              s1_res;
  logic              s1_last;
  logic [AW-1:0]     s1_addr;
  logic [CODE_W-1:0] s1_pixw;
  logic              s1_use_up;
  logic              s1_use_down;
  logic              s1_use_left;
  logic              s1_use_right;
  logic              s1_row_end;
  logic              s1_anom;
  logic              s1_w2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_wr        <= !last;
      s1_res       <= has_res;
      s1_last      <= last;
      s1_addr      <= in_col;
      // pixels after the frame end are stored as zero
      s1_pixw      <= in_frame ? pix_req.pixel_in : '0;
      s1_use_up    <= out_row != '0;
      s1_use_down  <= !out_row_last;
      s1_use_left  <= out_col != '0;
      s1_use_right <= !out_col_last;
      s1_row_end   <= out_col_last;
      // after a row wrap the last result reads stale columns of the line memories
      s1_anom      <= wrapped && (w_eff != XW'(1));
      s1_w2        <= w_eff == XW'(2);
    end
  end

  // Same-address read and write in one cycle only happens at width one: forward.
  logic              fwd;
  logic [CODE_W-1:0] fwd_u;
  logic [CODE_W-1:0] fwd_m;
  logic [CODE_W-1:0] u_rd;
  logic [CODE_W-1:0] m_rd;

  assign u_rd = fwd ? fwd_u : upper_q;
  assign m_rd = fwd ? fwd_m : middle_q;

  // shift the middle line up, store the new pixel in the middle line
  assign wr_en        = s1_valid && s1_wr;
  assign wr_addr      = s1_addr;
  assign upper_wdata  = m_rd;
  assign middle_wdata = s1_pixw;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= rd_en && wr_en && (rd_addr == wr_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_u <= upper_wdata;
    fwd_m <= middle_wdata;
  end

  // Window history from the previous steps:
  //   up_h   : upper line value evicted last step (pixel t-W)
  //   ctr_h  : middle line value read last step (pixel t)
  //   left_h : middle line value read two steps back (pixel t-1)
  //   down_h : value stored into the middle line last step (pixel t+W)
  logic [CODE_W-1:0] up_h;
  logic [CODE_W-1:0] ctr_h;
  logic [CODE_W-1:0] left_h;
  logic [CODE_W-1:0] down_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_h <= '0;
    end else if (wr_en) begin
      up_h <= u_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ctr_h  <= m_rd;
      left_h <= ctr_h;
      down_h <= s1_pixw;
    end
  end

  logic [CODE_W-1:0] center;
  logic [CODE_W-1:0] left;
  logic              erode;
  cef_out_t          s1_out;

  always_comb begin
    // After the wrap the centre column holds flushed zeros; at width two the left
    // column has already been refilled with the first new pixel.
    center = s1_anom ? '0 : ctr_h;
    left   = (s1_anom && s1_w2) ? ctr_h : left_h;
    erode  = (center == cfg_fg) &&
             ((s1_use_up    && up_h   == cfg_bg) ||
              (s1_use_down  && down_h == cfg_bg) ||
              (s1_use_left  && left   == cfg_bg) ||
              (s1_use_right && m_rd   == cfg_bg));
    s1_out.pixel_out = erode ? cfg_bg : center;
    s1_out.row_end   = s1_row_end;
    s1_out.frame_end = s1_last;
  end

  // ---------------------------------------------------------------------------
  // Result queue: decouples the output handshake from the compute stage
  // ---------------------------------------------------------------------------
  cef_out_t         q_mem [QD];
  logic [QAW-1:0]   q_wp;
  logic [QAW-1:0]   q_rp;
  logic [QAW:0]     q_count;
  logic             q_push;
  logic             q_pop;

  assign q_push    = s1_valid && s1_res;
  assign q_pop     = ero_valid && ero_ready;
  assign ero_valid = q_count != '0;
  assign ero_req   = q_mem[q_rp];
  // hold requests once the queue could not absorb everything in flight
  assign pix_ready = (q_count + (QAW+1)'(s1_valid)) < (QAW+1)'(QD);

  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      q_wp    <= '0;
      q_rp    <= '0;
      q_count <= '0;
    end else begin
      if (q_push) begin
        q_wp <= q_wp + QAW'(1);
      end
      if (q_pop) begin
        q_rp <= q_rp + QAW'(1);
      end
      q_count <= q_count + (QAW+1)'(q_push) - (QAW+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wp] <= s1_out;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count < (QAW+1)'(QD) || q_pop))
    else $error("result queue overflow");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (rst)
    (ero_valid && ero_req.frame_end) |-> ero_req.row_end)
    else $error("frame end without row end");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (step && last) |=> (in_col == '0 && in_pos == '0 && out_row == '0 && !wrapped))
    else $error("counters not cleared after frame end");

  a_stage_source: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(pix_valid && pix_ready))
    else $error("compute stage active without an accepted request");

endmodule

`default_nettype wire
